// File: src/gas_pkg.sv
// ----------------------------------------------------------------------------
// Grid A* path search - shared package
// Widths, codes, request records and small helper functions used by the
// front end, the search engine and the top level.
// ----------------------------------------------------------------------------
package gas_pkg;

    localparam int MAX_GRID_X = 64;
    localparam int MAX_GRID_Y = 64;
    localparam int CELLS      = MAX_GRID_X * MAX_GRID_Y;
    localparam int CELL_W     = $clog2(CELLS);
    localparam int CNT_W      = CELL_W + 1;
    localparam int XY_W       = 6;
    localparam int SZ_W       = 7;
    localparam int COST_W     = 32;
    localparam int SEQ_W      = 16;
    localparam int LIM_W      = 13;
    localparam int CFG_DW     = 13;
    localparam int CFG_IW     = 2;

    localparam logic [COST_W-1:0] STEP_STRAIGHT = 32'd65536;
    localparam logic [COST_W-1:0] STEP_DIAG     = 32'd92682;
    localparam logic [23:0]       TIE_Q16       = 24'd65543;

    // node status codes as held in the status memory
    localparam logic [1:0] NS_FREE   = 2'd0;
    localparam logic [1:0] NS_OPEN   = 2'd1;
    localparam logic [1:0] NS_CLOSED = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_ALLOW_DIAG  = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_EXP_LIMIT   = 2'd3;

    typedef enum logic [1:0] {
        OP_SET    = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_SEARCH = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_DONE   = 3'd0,
        ST_FOUND  = 3'd1,
        ST_NOPATH = 3'd2,
        ST_LIMIT  = 3'd3,
        ST_RANGE  = 3'd4
    } t_status;

    typedef struct packed {
        logic [SZ_W-1:0]  w;
        logic [SZ_W-1:0]  h;
        logic             diag;
        logic [LIM_W-1:0] limit;
    } t_cfg;

    typedef struct packed {
        t_op               op;
        logic [XY_W-1:0]   x;
        logic [XY_W-1:0]   y;
        logic [XY_W-1:0]   gx;
        logic [XY_W-1:0]   gy;
        logic [CELL_W-1:0] idx;
        logic              in_grid;
    } t_cmd;

    typedef struct packed {
        logic take;
        logic init_done;
    } t_eng_stat;

    typedef struct packed {
        t_status           status;
        logic [CNT_W-1:0]  len;
        logic [COST_W-1:0] cost;
        logic [XY_W-1:0]   x;
        logic [XY_W-1:0]   y;
    } t_result;

    // open list entry: key, insertion number and cell coordinates
    typedef struct packed {
        logic [COST_W-1:0] f;
        logic [SEQ_W-1:0]  seq;
        logic [XY_W-1:0]   x;
        logic [XY_W-1:0]   y;
    } t_qent;

    function automatic logic [CELL_W-1:0] cell_of(input logic [XY_W-1:0] x,
                                                  input logic [XY_W-1:0] y,
                                                  input logic [SZ_W-1:0] h);
        logic [CNT_W:0] p;
        p = (CNT_W+1)'(x) * (CNT_W+1)'(h) + (CNT_W+1)'(y);
        return p[CELL_W-1:0];
    endfunction

    function automatic logic [XY_W-1:0] absdiff(input logic [XY_W-1:0] a,
                                                input logic [XY_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [COST_W-1:0] heur(input logic [XY_W-1:0] x,
                                               input logic [XY_W-1:0] y,
                                               input logic [XY_W-1:0] gx,
                                               input logic [XY_W-1:0] gy);
        logic [23:0] s;
        s = 24'(absdiff(x, gx)) + 24'(absdiff(y, gy));
        return COST_W'(s * TIE_Q16);
    endfunction

    // neighbour move index k = 3*di + dj, di and dj in 0..2
    function automatic logic [1:0] nb_di(input logic [3:0] k);
        case (k)
            4'd0, 4'd1, 4'd2: return 2'd0;
            4'd3, 4'd4, 4'd5: return 2'd1;
            default:          return 2'd2;
        endcase
    endfunction

    function automatic logic [1:0] nb_dj(input logic [3:0] k);
        case (k)
            4'd0, 4'd3, 4'd6: return 2'd0;
            4'd1, 4'd4, 4'd7: return 2'd1;
            default:          return 2'd2;
        endcase
    endfunction

    // stored parent direction (centre move removed) back to di / dj
    function automatic logic [1:0] dir_di(input logic [2:0] d);
        case (d)
            3'd0, 3'd1, 3'd2: return 2'd0;
            3'd3, 3'd4:       return 2'd1;
            default:          return 2'd2;
        endcase
    endfunction

    function automatic logic [1:0] dir_dj(input logic [2:0] d);
        case (d)
            3'd0, 3'd3, 3'd5: return 2'd0;
            3'd1, 3'd6:       return 2'd1;
            default:          return 2'd2;
        endcase
    endfunction

endpackage

// File: src/gas_front.sv
// ----------------------------------------------------------------------------
// Grid A* path search - request front end
// Accepts requests, decodes and clamps them, and holds them in a two-entry
// queue until the search engine takes them.
// ----------------------------------------------------------------------------
module gas_front import gas_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [1:0]      i_req_type,
    input  logic [XY_W-1:0] i_cell_x,
    input  logic [XY_W-1:0] i_cell_y,
    input  logic [XY_W-1:0] i_goal_x,
    input  logic [XY_W-1:0] i_goal_y,
    input  logic [11:0]     i_path_index,
    input  t_cfg            i_cfg,
    input  t_eng_stat       i_eng,
    output logic            o_busy,
    output logic            o_cmd_valid,
    output t_cmd            o_cmd
);

    t_cmd       r_fifo [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;
    t_cmd       dec;
    logic [SZ_W-1:0] wm1;
    logic [SZ_W-1:0] hm1;

    assign wm1 = i_cfg.w - SZ_W'(1);
    assign hm1 = i_cfg.h - SZ_W'(1);

    always_comb begin
        dec.op      = t_op'(i_req_type);
        dec.idx     = i_path_index;
        dec.in_grid = (SZ_W'(i_cell_x) < i_cfg.w) && (SZ_W'(i_cell_y) < i_cfg.h);
        if (dec.op == OP_SEARCH) begin
            dec.x = (SZ_W'(i_cell_x) > wm1) ? wm1[XY_W-1:0] : i_cell_x;
            dec.y = (SZ_W'(i_cell_y) > hm1) ? hm1[XY_W-1:0] : i_cell_y;
        end else begin
            dec.x = i_cell_x;
            dec.y = i_cell_y;
        end
        dec.gx = (SZ_W'(i_goal_x) > wm1) ? wm1[XY_W-1:0] : i_goal_x;
        dec.gy = (SZ_W'(i_goal_y) > hm1) ? hm1[XY_W-1:0] : i_goal_y;
    end

    assign o_busy      = (r_cnt == 2'd2) || !i_eng.init_done;
    assign push        = i_start && !o_busy;
    assign pop         = i_eng.take;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_fifo[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wp] <= dec;
        end
    end

endmodule

// File: src/gas_engine.sv
// ----------------------------------------------------------------------------
// Grid A* path search - search engine
// Sequencer that owns the grid memories and the open list. It carries out
// obstacle writes, map clears, A* searches and path reads one at a time.
// ----------------------------------------------------------------------------
module gas_engine import gas_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output t_eng_stat o_stat,
    output logic      o_res_valid,
    output t_result   o_res
);

    typedef enum logic [25:0] {
        S_INIT       = 26'd1 << 0,
        S_IDLE       = 26'd1 << 1,
        S_OBS_W      = 26'd1 << 2,
        S_CLR_SWEEP  = 26'd1 << 3,
        S_SRCH_SWEEP = 26'd1 << 4,
        S_SRCH_INIT  = 26'd1 << 5,
        S_POP_CHK    = 26'd1 << 6,
        S_SCAN       = 26'd1 << 7,
        S_POP_LAST   = 26'd1 << 8,
        S_POP_WAIT   = 26'd1 << 9,
        S_POP_MOVE   = 26'd1 << 10,
        S_POP_CLOSE  = 26'd1 << 11,
        S_POP_TEST   = 26'd1 << 12,
        S_NB_ADDR    = 26'd1 << 13,
        S_NB_WAIT    = 26'd1 << 14,
        S_NB_DATA    = 26'd1 << 15,
        S_NB_ACT     = 26'd1 << 16,
        S_NB_END     = 26'd1 << 17,
        S_W1_CHK     = 26'd1 << 18,
        S_W1_WAIT    = 26'd1 << 19,
        S_W1_STEP    = 26'd1 << 20,
        S_W2_WR      = 26'd1 << 21,
        S_W2_WAIT    = 26'd1 << 22,
        S_W2_STEP    = 26'd1 << 23,
        S_RD_WAIT    = 26'd1 << 24,
        S_RD_OUT     = 26'd1 << 25
    } t_state;

    // memories
    logic                 r_obst_mem [CELLS];
    logic [1:0]           r_nst_mem  [CELLS];
    logic [COST_W-1:0]    r_g_mem    [CELLS];
    logic [2:0]           r_pdir_mem [CELLS];
    logic [CELL_W-1:0]    r_qpos_mem [CELLS];
    t_qent                r_q_mem    [CELLS];
    logic [2*XY_W-1:0]    r_path_mem [CELLS];

    logic                 r_obst_rd;
    logic [1:0]           r_nst_rd;
    logic [COST_W-1:0]    r_g_rd;
    logic [2:0]           r_pdir_rd;
    logic [CELL_W-1:0]    r_qpos_rd;
    t_qent                r_qrd;
    logic [2*XY_W-1:0]    r_path_rd;

    // control registers
    t_state            r_state, n_state;
    logic [CELL_W-1:0] r_addr, n_addr;
    logic [CNT_W-1:0]  r_plen, n_plen;
    logic              r_ovalid, n_ovalid;

    // working registers
    logic [CELL_W-1:0] r_qaddr, n_qaddr;
    logic [CELL_W-1:0] r_paddr, n_paddr;
    logic [CNT_W-1:0]  r_scan, n_scan;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SEQ_W-1:0]  r_seq, n_seq;
    logic [LIM_W-1:0]  r_pops, n_pops;
    logic [XY_W-1:0]   r_sx, n_sx, r_sy, n_sy, r_gx, n_gx, r_gy, n_gy;
    logic [XY_W-1:0]   r_cx, n_cx, r_cy, n_cy;
    logic [XY_W-1:0]   r_nx, n_nx, r_ny, n_ny;
    logic [XY_W-1:0]   r_wx, n_wx, r_wy, n_wy;
    logic [3:0]        r_k, n_k;
    logic [COST_W-1:0] r_heur, n_heur;
    logic              r_diag, n_diag;
    logic [COST_W-1:0] r_g, n_g;
    logic [COST_W-1:0] r_gcur, n_gcur;
    logic              r_new, n_new;
    logic [CELL_W-1:0] r_qposv, n_qposv;
    t_qent             r_best, n_best;
    logic [CELL_W-1:0] r_bi, n_bi;
    logic              r_first, n_first;
    logic              r_pend, n_pend;
    logic [CELL_W-1:0] r_pidx, n_pidx;
    logic [CNT_W-1:0]  r_n, n_n, r_i, n_i;
    logic [COST_W-1:0] r_cost, n_cost;
    logic [CELL_W-1:0] r_idx, n_idx;
    logic              r_obs_ok, n_obs_ok;
    t_result           r_res, n_res;

    // memory write controls
    logic              obst_we, obst_wd;
    logic              nst_we;
    logic [1:0]        nst_wd;
    logic              g_we;
    logic [COST_W-1:0] g_wd;
    logic              pdir_we;
    logic              qpos_we;
    logic [CELL_W-1:0] qpos_wa, qpos_wd;
    logic              q_we;
    logic [CELL_W-1:0] q_wa;
    t_qent             q_wd;
    logic              path_we;

    // neighbour evaluation
    logic [1:0]        di, dj;
    logic              nb_diag, nb_skip;
    logic [SZ_W-1:0]   nx7, ny7;
    logic [COST_W-1:0] g_new, f_new;
    logic [2:0]        dir_code;
    logic              better, last_k;
    logic [XY_W-1:0]   par_x, par_y;

    assign di       = nb_di(r_k);
    assign dj       = nb_dj(r_k);
    assign nb_diag  = (di != 2'd1) && (dj != 2'd1);
    assign nx7      = SZ_W'(r_cx) + SZ_W'(di) - SZ_W'(1);
    assign ny7      = SZ_W'(r_cy) + SZ_W'(dj) - SZ_W'(1);
    assign nb_skip  = (r_k == 4'd4) || (!i_cfg.diag && nb_diag)
                   || ((di == 2'd0) && (r_cx == '0)) || ((dj == 2'd0) && (r_cy == '0))
                   || (nx7 >= i_cfg.w) || (ny7 >= i_cfg.h);
    assign last_k   = (r_k == 4'd8);
    assign g_new    = r_gcur + (r_diag ? STEP_DIAG : STEP_STRAIGHT);
    assign f_new    = r_g + r_heur;
    assign dir_code = (r_k < 4'd4) ? r_k[2:0] : 3'(r_k - 4'd1);
    assign better   = (r_qrd.f < r_best.f)
                   || ((r_qrd.f == r_best.f) && (r_qrd.seq < r_best.seq));
    assign par_x    = r_wx + XY_W'(1) - XY_W'(dir_di(r_pdir_rd));
    assign par_y    = r_wy + XY_W'(1) - XY_W'(dir_dj(r_pdir_rd));

    assign o_stat.take      = (r_state == S_IDLE) && i_cmd_valid;
    assign o_stat.init_done = (r_state != S_INIT);
    assign o_res_valid      = r_ovalid;
    assign o_res            = r_res;

    always_comb begin
        n_state = r_state;  n_addr = r_addr;   n_plen = r_plen;   n_ovalid = 1'b0;
        n_qaddr = r_qaddr;  n_paddr = r_paddr; n_scan = r_scan;   n_count = r_count;
        n_seq = r_seq;      n_pops = r_pops;   n_sx = r_sx;       n_sy = r_sy;
        n_gx = r_gx;        n_gy = r_gy;       n_cx = r_cx;       n_cy = r_cy;
        n_nx = r_nx;        n_ny = r_ny;       n_wx = r_wx;       n_wy = r_wy;
        n_k = r_k;          n_heur = r_heur;   n_diag = r_diag;   n_g = r_g;
        n_gcur = r_gcur;    n_new = r_new;     n_qposv = r_qposv; n_best = r_best;
        n_bi = r_bi;        n_first = r_first; n_pend = r_pend;   n_pidx = r_pidx;
        n_n = r_n;          n_i = r_i;         n_cost = r_cost;   n_idx = r_idx;
        n_obs_ok = r_obs_ok; n_res = r_res;

        obst_we = 1'b0;  obst_wd = 1'b0;
        nst_we  = 1'b0;  nst_wd  = NS_FREE;
        g_we    = 1'b0;  g_wd    = r_g;
        pdir_we = 1'b0;
        qpos_we = 1'b0;  qpos_wa = r_addr;  qpos_wd = r_count[CELL_W-1:0];
        q_we    = 1'b0;  q_wa    = r_count[CELL_W-1:0];
        q_wd    = '{f: f_new, seq: r_seq, x: r_nx, y: r_ny};
        path_we = 1'b0;

        case (r_state)
            S_INIT: begin
                obst_we = 1'b1;
                n_addr  = r_addr + CELL_W'(1);
                if (r_addr == CELL_W'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_res = '{status: ST_DONE, len: '0, cost: '0, x: '0, y: '0};
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        OP_SET: begin
                            n_addr   = cell_of(i_cmd.x, i_cmd.y, i_cfg.h);
                            n_obs_ok = i_cmd.in_grid;
                            n_state  = S_OBS_W;
                        end
                        OP_CLEAR: begin
                            n_addr  = '0;
                            n_state = S_CLR_SWEEP;
                        end
                        OP_SEARCH: begin
                            n_sx    = i_cmd.x;
                            n_sy    = i_cmd.y;
                            n_gx    = i_cmd.gx;
                            n_gy    = i_cmd.gy;
                            n_heur  = heur(i_cmd.x, i_cmd.y, i_cmd.gx, i_cmd.gy);
                            n_plen  = '0;
                            n_addr  = '0;
                            n_state = S_SRCH_SWEEP;
                        end
                        OP_READ: begin
                            n_paddr = i_cmd.idx;
                            n_idx   = i_cmd.idx;
                            n_state = S_RD_WAIT;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_OBS_W: begin
                obst_we  = r_obs_ok;
                obst_wd  = 1'b1;
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            S_CLR_SWEEP: begin
                obst_we = 1'b1;
                n_addr  = r_addr + CELL_W'(1);
                if (r_addr == CELL_W'(CELLS - 1)) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_SRCH_SWEEP: begin
                nst_we = 1'b1;
                n_addr = r_addr + CELL_W'(1);
                if (r_addr == CELL_W'(CELLS - 1)) begin
                    n_addr  = cell_of(r_sx, r_sy, i_cfg.h);
                    n_state = S_SRCH_INIT;
                end
            end
            S_SRCH_INIT: begin
                g_we    = 1'b1;
                g_wd    = '0;
                nst_we  = 1'b1;
                nst_wd  = NS_OPEN;
                q_we    = 1'b1;
                q_wa    = '0;
                q_wd    = '{f: r_heur, seq: '0, x: r_sx, y: r_sy};
                qpos_we = 1'b1;
                qpos_wd = '0;
                n_count = CNT_W'(1);
                n_seq   = SEQ_W'(1);
                n_pops  = '0;
                n_state = S_POP_CHK;
            end
            S_POP_CHK: begin
                if (r_count == '0) begin
                    n_res    = '{status: ST_NOPATH, len: '0, cost: '0, x: '0, y: '0};
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_scan  = '0;
                    n_qaddr = '0;
                    n_pend  = 1'b0;
                    n_first = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_pend = (r_scan < r_count);
                n_pidx = r_qaddr;
                if (r_scan < r_count) begin
                    n_scan  = r_scan + CNT_W'(1);
                    n_qaddr = r_qaddr + CELL_W'(1);
                end
                if (r_pend && (r_first || better)) begin
                    n_best  = r_qrd;
                    n_bi    = r_pidx;
                    n_first = 1'b0;
                end
                if (!(r_scan < r_count) && !r_pend) begin
                    n_state = S_POP_LAST;
                end
            end
            S_POP_LAST: begin
                n_count = r_count - CNT_W'(1);
                n_qaddr = CELL_W'(r_count - CNT_W'(1));
                n_state = S_POP_WAIT;
            end
            S_POP_WAIT: n_state = S_POP_MOVE;
            S_POP_MOVE: begin
                // last entry fills the hole left by the popped one
                q_we    = 1'b1;
                q_wa    = r_bi;
                q_wd    = r_qrd;
                qpos_we = 1'b1;
                qpos_wa = cell_of(r_qrd.x, r_qrd.y, i_cfg.h);
                qpos_wd = r_bi;
                n_cx    = r_best.x;
                n_cy    = r_best.y;
                n_addr  = cell_of(r_best.x, r_best.y, i_cfg.h);
                n_state = S_POP_CLOSE;
            end
            S_POP_CLOSE: begin
                nst_we  = 1'b1;
                nst_wd  = NS_CLOSED;
                n_pops  = r_pops + LIM_W'(1);
                n_state = S_POP_TEST;
            end
            S_POP_TEST: begin
                if ((r_cx == r_gx) && (r_cy == r_gy)) begin
                    n_cost  = r_g_rd;
                    n_wx    = r_gx;
                    n_wy    = r_gy;
                    n_n     = CNT_W'(1);
                    n_state = S_W1_CHK;
                end else begin
                    n_gcur  = r_g_rd;
                    n_k     = '0;
                    n_state = S_NB_ADDR;
                end
            end
            S_NB_ADDR: begin
                if (nb_skip) begin
                    n_k     = r_k + 4'd1;
                    n_state = last_k ? S_NB_END : S_NB_ADDR;
                end else begin
                    n_nx    = nx7[XY_W-1:0];
                    n_ny    = ny7[XY_W-1:0];
                    n_addr  = cell_of(nx7[XY_W-1:0], ny7[XY_W-1:0], i_cfg.h);
                    n_heur  = heur(nx7[XY_W-1:0], ny7[XY_W-1:0], r_gx, r_gy);
                    n_diag  = nb_diag;
                    n_state = S_NB_WAIT;
                end
            end
            S_NB_WAIT: n_state = S_NB_DATA;
            S_NB_DATA: begin
                n_g     = g_new;
                n_qposv = r_qpos_rd;
                n_new   = (r_nst_rd == NS_FREE);
                if (r_obst_rd || (r_nst_rd == NS_CLOSED)
                    || ((r_nst_rd != NS_FREE) && !(r_g_rd > g_new))) begin
                    n_k     = r_k + 4'd1;
                    n_state = last_k ? S_NB_END : S_NB_ADDR;
                end else begin
                    n_state = S_NB_ACT;
                end
            end
            S_NB_ACT: begin
                g_we    = 1'b1;
                pdir_we = 1'b1;
                q_we    = 1'b1;
                n_seq   = r_seq + SEQ_W'(1);
                if (r_new) begin
                    nst_we  = 1'b1;
                    nst_wd  = NS_OPEN;
                    qpos_we = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end else begin
                    q_wa = r_qposv;
                end
                n_k     = r_k + 4'd1;
                n_state = last_k ? S_NB_END : S_NB_ADDR;
            end
            S_NB_END: begin
                if (r_pops >= i_cfg.limit) begin
                    n_res    = '{status: ST_LIMIT, len: '0, cost: '0, x: '0, y: '0};
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_POP_CHK;
                end
            end
            S_W1_CHK: begin
                if ((r_wx == r_sx) && (r_wy == r_sy)) begin
                    n_wx    = r_gx;
                    n_wy    = r_gy;
                    n_i     = r_n;
                    n_state = S_W2_WR;
                end else begin
                    n_addr  = cell_of(r_wx, r_wy, i_cfg.h);
                    n_state = S_W1_WAIT;
                end
            end
            S_W1_WAIT: n_state = S_W1_STEP;
            S_W1_STEP: begin
                n_wx    = par_x;
                n_wy    = par_y;
                n_n     = r_n + CNT_W'(1);
                n_state = S_W1_CHK;
            end
            S_W2_WR: begin
                path_we = 1'b1;
                if (r_i == CNT_W'(1)) begin
                    n_plen   = r_n;
                    n_res    = '{status: ST_FOUND, len: r_n, cost: r_cost, x: '0, y: '0};
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_addr  = cell_of(r_wx, r_wy, i_cfg.h);
                    n_state = S_W2_WAIT;
                end
            end
            S_W2_WAIT: n_state = S_W2_STEP;
            S_W2_STEP: begin
                n_wx    = par_x;
                n_wy    = par_y;
                n_i     = r_i - CNT_W'(1);
                n_state = S_W2_WR;
            end
            S_RD_WAIT: n_state = S_RD_OUT;
            S_RD_OUT: begin
                if (CNT_W'(r_idx) < r_plen) begin
                    n_res = '{status: ST_DONE, len: r_plen, cost: '0,
                              x: r_path_rd[2*XY_W-1:XY_W], y: r_path_rd[XY_W-1:0]};
                end else begin
                    n_res = '{status: ST_RANGE, len: r_plen, cost: '0, x: '0, y: '0};
                end
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_addr   <= '0;
            r_plen   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_plen   <= n_plen;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_qaddr <= n_qaddr;  r_paddr <= n_paddr;  r_scan <= n_scan;   r_count <= n_count;
        r_seq <= n_seq;      r_pops <= n_pops;    r_sx <= n_sx;       r_sy <= n_sy;
        r_gx <= n_gx;        r_gy <= n_gy;        r_cx <= n_cx;       r_cy <= n_cy;
        r_nx <= n_nx;        r_ny <= n_ny;        r_wx <= n_wx;       r_wy <= n_wy;
        r_k <= n_k;          r_heur <= n_heur;    r_diag <= n_diag;   r_g <= n_g;
        r_gcur <= n_gcur;    r_new <= n_new;      r_qposv <= n_qposv; r_best <= n_best;
        r_bi <= n_bi;        r_first <= n_first;  r_pend <= n_pend;   r_pidx <= n_pidx;
        r_n <= n_n;          r_i <= n_i;          r_cost <= n_cost;   r_idx <= n_idx;
        r_obs_ok <= n_obs_ok; r_res <= n_res;
    end

    // memories; cell-indexed ones read at the working cell address
    always_ff @(posedge i_clk) begin
        if (obst_we) begin
            r_obst_mem[r_addr] <= obst_wd;
        end
        r_obst_rd <= r_obst_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (nst_we) begin
            r_nst_mem[r_addr] <= nst_wd;
        end
        r_nst_rd <= r_nst_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (g_we) begin
            r_g_mem[r_addr] <= g_wd;
        end
        r_g_rd <= r_g_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (pdir_we) begin
            r_pdir_mem[r_addr] <= dir_code;
        end
        r_pdir_rd <= r_pdir_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (qpos_we) begin
            r_qpos_mem[qpos_wa] <= qpos_wd;
        end
        r_qpos_rd <= r_qpos_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_q_mem[q_wa] <= q_wd;
        end
        r_qrd <= r_q_mem[r_qaddr];
    end

    always_ff @(posedge i_clk) begin
        if (path_we) begin
            r_path_mem[CELL_W'(r_i - CNT_W'(1))] <= {r_wx, r_wy};
        end
        r_path_rd <= r_path_mem[r_paddr];
    end

endmodule

// File: src/grid_astar_path_search_unit.sv
// ----------------------------------------------------------------------------
// Grid A* path search unit - top level
// Holds the configuration registers and joins the request front end to the
// search engine.
// ----------------------------------------------------------------------------
// Usage. A request (set obstacle, clear map, search, read path cell) is
// accepted at a rising edge where start is high and busy is low. A two-entry
// request queue sits in front of the engine, so a new request may be taken
// while the engine is still working on an earlier one; after the reset
// pass, busy rises only when the queue is full. Every request gives exactly
// one result, shown on the o_ result ports for one cycle with o_valid high.
// The receiver cannot hold results off and none is ever delayed for it.
// Work per request: a set obstacle writes at most one obstacle cell and a
// path read reads one path cell. A clear map sweeps the obstacle memory.
// A search first sweeps the node status memory, then for each popped node
// scans the whole open list, one entry a cycle through the open list memory
// port, and then tests each of the eight neighbours; a found path is walked
// back to the start once to count its cells and once more to write them.
// After reset the engine clears the obstacle memory in a single pass;
// busy stays high during that pass. Configuration is written through the
// plain write port and should only change while the unit is idle.
// ----------------------------------------------------------------------------
module grid_astar_path_search_unit import gas_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_req_type,
    input  logic [XY_W-1:0]   i_cell_x,
    input  logic [XY_W-1:0]   i_cell_y,
    input  logic [XY_W-1:0]   i_goal_x,
    input  logic [XY_W-1:0]   i_goal_y,
    input  logic [11:0]       i_path_index,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    output logic              o_valid,
    output logic [2:0]        o_status,
    output logic [12:0]       o_path_length,
    output logic [31:0]       o_path_cost,
    output logic [XY_W-1:0]   o_path_x,
    output logic [XY_W-1:0]   o_path_y
);

    logic [SZ_W-1:0]  r_grid_width;
    logic [SZ_W-1:0]  r_grid_height;
    logic             r_allow_diag;
    logic [LIM_W-1:0] r_exp_limit;

    t_cfg      cfg;
    t_cmd      cmd;
    logic      cmd_valid;
    t_eng_stat eng_stat;
    t_result   res;

    // Register writes take effect at once; sizes are saturated to the
    // supported grid and a zero limit is treated as one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= SZ_W'(MAX_GRID_X);
            r_grid_height <= SZ_W'(MAX_GRID_Y);
            r_allow_diag  <= 1'b1;
            r_exp_limit   <= LIM_W'(4096);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_wdata[SZ_W-1:0];
                CFG_GRID_HEIGHT: r_grid_height <= i_cfg_wdata[SZ_W-1:0];
                CFG_ALLOW_DIAG:  r_allow_diag  <= i_cfg_wdata[0];
                CFG_EXP_LIMIT:   r_exp_limit   <= i_cfg_wdata[LIM_W-1:0];
                default:         r_allow_diag  <= r_allow_diag;
            endcase
        end
    end

    always_comb begin
        if (r_grid_width == '0) begin
            cfg.w = SZ_W'(1);
        end else if (r_grid_width > SZ_W'(MAX_GRID_X)) begin
            cfg.w = SZ_W'(MAX_GRID_X);
        end else begin
            cfg.w = r_grid_width;
        end
        if (r_grid_height == '0) begin
            cfg.h = SZ_W'(1);
        end else if (r_grid_height > SZ_W'(MAX_GRID_Y)) begin
            cfg.h = SZ_W'(MAX_GRID_Y);
        end else begin
            cfg.h = r_grid_height;
        end
        cfg.diag  = r_allow_diag;
        cfg.limit = (r_exp_limit == '0) ? LIM_W'(1) : r_exp_limit;
    end

    gas_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_req_type   (i_req_type),
        .i_cell_x     (i_cell_x),
        .i_cell_y     (i_cell_y),
        .i_goal_x     (i_goal_x),
        .i_goal_y     (i_goal_y),
        .i_path_index (i_path_index),
        .i_cfg        (cfg),
        .i_eng        (eng_stat),
        .o_busy       (busy),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd)
    );

    gas_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_stat      (eng_stat),
        .o_res_valid (o_valid),
        .o_res       (res)
    );

    assign o_status      = res.status;
    assign o_path_length = res.len;
    assign o_path_cost   = res.cost;
    assign o_path_x      = res.x;
    assign o_path_y      = res.y;

`ifndef SYNTHESIS
    // Each result is strobed as the engine returns to idle, and idle never strobes, so strobes never abut.
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_RANGE)) |-> ((o_path_x == '0) && (o_path_y == '0)))
        else $error("out-of-range read returned a cell");

    a_found_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FOUND)) |-> (o_path_length != '0))
        else $error("found path reported with zero length");

    a_fail_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_status == ST_NOPATH) || (o_status == ST_LIMIT)))
        |-> ((o_path_length == '0) && (o_path_cost == '0)))
        else $error("failed search reported a path");
`endif

endmodule

// File: dv/grid_astar_path_search_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Grid A* path search unit - self-checking testbench
// Sends obstacle, clear, search and path read requests through the start/busy
// handshake. A behavioural A* model inside the bench predicts every result.
// A monitor compares each strobed result with the oldest prediction. Directed
// corner cases come first, followed by randomised map and search traffic over
// many register settings.
// ----------------------------------------------------------------------------
module grid_astar_path_search_unit_tb;
    import gas_pkg::*;

    // Clock, reset and the ports of the unit.
    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_req_type;
    logic [XY_W-1:0]   i_cell_x, i_cell_y, i_goal_x, i_goal_y;
    logic [11:0]       i_path_index;
    logic              i_cfg_we;
    logic [CFG_IW-1:0] i_cfg_index;
    logic [CFG_DW-1:0] i_cfg_wdata;
    logic              o_valid;
    logic [2:0]        o_status;
    logic [12:0]       o_path_length;
    logic [31:0]       o_path_cost;
    logic [XY_W-1:0]   o_path_x, o_path_y;

    always #6 i_clk = ~i_clk;

    grid_astar_path_search_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_cell_x(i_cell_x), .i_cell_y(i_cell_y),
        .i_goal_x(i_goal_x), .i_goal_y(i_goal_y), .i_path_index(i_path_index),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata),
        .o_valid(o_valid), .o_status(o_status), .o_path_length(o_path_length),
        .o_path_cost(o_path_cost), .o_path_x(o_path_x), .o_path_y(o_path_y)
    );

    // One predicted result of a request.
    typedef struct {
        logic [2:0]      status;
        logic [12:0]     len;
        logic [31:0]     cost;
        logic [XY_W-1:0] x;
        logic [XY_W-1:0] y;
    } t_answer;

    t_answer answers_due[$];
    int      fail_count = 0;
    int      sent_count = 0;

    // Bench copy of the unit's state and registers.
    bit              obst_map[CELLS];
    logic [1:0]      node_state[CELLS];
    logic [31:0]     g_score[CELLS];
    logic [2:0]      came_from[CELLS];
    logic [31:0]     open_f[CELLS];
    logic [15:0]     open_seq[CELLS];
    int              open_cell[CELLS];
    int              open_n;
    logic [15:0]     next_seq;
    logic [XY_W-1:0] route_x[CELLS];
    logic [XY_W-1:0] route_y[CELLS];
    int              route_len;
    int              reg_w, reg_h, reg_diag, reg_limit;

    function automatic int sat_size(input int v);
        return (v < 1) ? 1 : ((v > 64) ? 64 : v);
    endfunction

    function automatic logic [31:0] manhattan(input int x, input int y,
                                              input int gx, input int gy);
        int d;
        d = ((x > gx) ? x - gx : gx - x) + ((y > gy) ? y - gy : gy - y);
        return 32'(d) * 32'd65543;
    endfunction

    function automatic void open_push(input logic [31:0] f, input int c);
        if (open_n >= CELLS) return;
        open_f[open_n] = f;
        open_seq[open_n] = next_seq;
        open_cell[open_n] = c;
        next_seq++;
        open_n++;
    endfunction

    // Cheapest f wins; equal keys go to the lowest insertion number.
    function automatic int open_pop();
        int best, i, c;
        best = 0;
        for (i = 1; i < open_n; i++)
            if (open_f[i] < open_f[best] ||
                (open_f[i] == open_f[best] && open_seq[i] < open_seq[best]))
                best = i;
        c = open_cell[best];
        open_n--;
        open_f[best] = open_f[open_n];
        open_seq[best] = open_seq[open_n];
        open_cell[best] = open_cell[open_n];
        return c;
    endfunction

    // A lowered key is treated as a fresh insertion.
    function automatic void open_rekey(input int c, input logic [31:0] f);
        int i;
        for (i = 0; i < open_n; i++)
            if (open_cell[i] == c) begin
                open_f[i] = f;
                open_seq[i] = next_seq;
                next_seq++;
                return;
            end
    endfunction

    // Step back from cell c along its stored parent direction.
    function automatic int parent_of(input int c, input int h);
        int k;
        k = (came_from[c] < 4) ? came_from[c] : came_from[c] + 1;
        return (c / h - k / 3 + 1) * h + (c % h - k % 3 + 1);
    endfunction

    function automatic void astar_search(input int sx, input int sy, input int gx,
                                         input int gy, output logic [2:0] st,
                                         output logic [31:0] cost);
        int w, h, lim, pops, src, dst, cur, cx, cy, k, di, dj, nx, ny, nc, n, c, i;
        bit dg;
        logic [31:0] g;
        w = sat_size(reg_w);
        h = sat_size(reg_h);
        lim = (reg_limit < 1) ? 1 : reg_limit;
        pops = 0;
        for (i = 0; i < CELLS; i++) node_state[i] = NS_FREE;
        open_n = 0;
        next_seq = 0;
        route_len = 0;
        cost = 0;
        st = ST_NOPATH;
        src = sx * h + sy;
        dst = gx * h + gy;
        g_score[src] = 0;
        node_state[src] = NS_OPEN;
        open_push(manhattan(sx, sy, gx, gy), src);
        while (open_n > 0) begin
            cur = open_pop();
            cx = cur / h;
            cy = cur % h;
            node_state[cur] = NS_CLOSED;
            pops++;
            if (cur == dst) begin
                n = 1;
                c = dst;
                while (c != src && n < CELLS) begin
                    c = parent_of(c, h);
                    n++;
                end
                c = dst;
                for (i = n; i > 0; i--) begin
                    route_x[i-1] = XY_W'(c / h);
                    route_y[i-1] = XY_W'(c % h);
                    if (i == 1) break;
                    c = parent_of(c, h);
                end
                route_len = n;
                cost = g_score[dst];
                st = ST_FOUND;
                return;
            end
            for (k = 0; k < 9; k++) begin
                di = k / 3;
                dj = k % 3;
                dg = (di != 1) && (dj != 1);
                if (k == 4) continue;
                if (reg_diag == 0 && dg) continue;
                if ((di == 0 && cx == 0) || (dj == 0 && cy == 0)) continue;
                nx = cx + di - 1;
                ny = cy + dj - 1;
                if (nx >= w || ny >= h) continue;
                nc = nx * h + ny;
                if (obst_map[nc] || node_state[nc] == NS_CLOSED) continue;
                g = g_score[cur] + (dg ? STEP_DIAG : STEP_STRAIGHT);
                if (node_state[nc] == NS_FREE) begin
                    g_score[nc] = g;
                    came_from[nc] = 3'((k < 4) ? k : k - 1);
                    node_state[nc] = NS_OPEN;
                    open_push(g + manhattan(nx, ny, gx, gy), nc);
                end else if (g_score[nc] > g) begin
                    g_score[nc] = g;
                    came_from[nc] = 3'((k < 4) ? k : k - 1);
                    open_rekey(nc, g + manhattan(nx, ny, gx, gy));
                end
            end
            if (pops >= lim) begin
                st = ST_LIMIT;
                return;
            end
        end
    endfunction

    // Works out the result of one accepted request and updates the state.
    function automatic t_answer predict_request(input t_op op, input int x, input int y,
                                                input int gx, input int gy,
                                                input int idx);
        t_answer a;
        int w, h, i;
        w = sat_size(reg_w);
        h = sat_size(reg_h);
        a = '{status: ST_DONE, len: 0, cost: 0, x: 0, y: 0};
        case (op)
            OP_SET: begin
                if (x < w && y < h) obst_map[x * h + y] = 1'b1;
            end
            OP_CLEAR: begin
                for (i = 0; i < CELLS; i++) obst_map[i] = 1'b0;
            end
            OP_SEARCH: begin
                if (x > w - 1) x = w - 1;
                if (y > h - 1) y = h - 1;
                if (gx > w - 1) gx = w - 1;
                if (gy > h - 1) gy = h - 1;
                astar_search(x, y, gx, gy, a.status, a.cost);
                a.len = 13'(route_len);
            end
            default: begin
                a.len = 13'(route_len);
                if (idx < route_len) begin
                    a.x = route_x[idx];
                    a.y = route_y[idx];
                end else begin
                    a.status = ST_RANGE;
                end
            end
        endcase
        return a;
    endfunction

    // Drives one request, waits for it to be taken, then leaves a random gap.
    // With no gap, start simply stays high for the following request.
    task automatic send_request(input t_op op, input int x, input int y, input int gx,
                                input int gy, input int idx);
        int gap;
        i_req_type   <= op;
        i_cell_x     <= XY_W'(x);
        i_cell_y     <= XY_W'(y);
        i_goal_x     <= XY_W'(gx);
        i_goal_y     <= XY_W'(gy);
        i_path_index <= 12'(idx);
        start        <= 1'b1;
        do @(posedge i_clk); while (busy);
        answers_due.push_back(predict_request(op, x, y, gx, gy, idx));
        sent_count++;
        @(negedge i_clk);
        gap = $urandom_range(0, 14);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Lowers start and waits until every outstanding request has answered.
    task automatic drain_requests();
        start <= 1'b0;
        while (answers_due.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Register writes happen only with the unit idle.
    task automatic write_register(input logic [CFG_IW-1:0] idx, input int val);
        drain_requests();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= CFG_DW'(val);
        case (idx)
            CFG_GRID_WIDTH:  reg_w = val & 127;
            CFG_GRID_HEIGHT: reg_h = val & 127;
            CFG_ALLOW_DIAG:  reg_diag = val & 1;
            default:         reg_limit = val & 8191;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_registers(input int w, input int h, input int dg, input int lim);
        write_register(CFG_GRID_WIDTH, w);
        write_register(CFG_GRID_HEIGHT, h);
        write_register(CFG_ALLOW_DIAG, dg);
        write_register(CFG_EXP_LIMIT, lim);
    endtask

    // Result monitor: every strobed result must match the oldest prediction.
    always @(posedge i_clk) begin
        t_answer a;
        if (i_rst_n && o_valid) begin
            if (answers_due.size() == 0) begin
                $error("result with no request outstanding: status %0d", o_status);
                fail_count++;
            end else begin
                a = answers_due.pop_front();
                if (o_status !== a.status) begin
                    $error("status: expected %0d, got %0d", a.status, o_status);
                    fail_count++;
                end
                if (o_path_length !== a.len) begin
                    $error("path_length: expected %0d, got %0d", a.len, o_path_length);
                    fail_count++;
                end
                if (o_path_cost !== a.cost) begin
                    $error("path_cost: expected %0d, got %0d", a.cost, o_path_cost);
                    fail_count++;
                end
                if (o_path_x !== a.x) begin
                    $error("path_x: expected %0d, got %0d", a.x, o_path_x);
                    fail_count++;
                end
                if (o_path_y !== a.y) begin
                    $error("path_y: expected %0d, got %0d", a.y, o_path_y);
                    fail_count++;
                end
            end
        end
    end

    // Reset values: a full 64 by 64 map with diagonals, a start that is also
    // the goal, and reads inside and far outside the one-cell path.
    task automatic test_reset_defaults();
        send_request(OP_SEARCH, 3, 3, 3, 3, 0);
        send_request(OP_READ, 0, 0, 0, 0, 0);
        send_request(OP_READ, 63, 63, 63, 63, 4095);
    endtask

    // Register extremes: sizes of 0 and 127 saturate, a limit of 0 acts as 1.
    task automatic test_register_extremes();
        set_registers(0, 127, 1, 4096);
        send_request(OP_SEARCH, 63, 63, 0, 0, 0);
        send_request(OP_READ, 0, 0, 0, 0, 63);
        set_registers(127, 0, 0, 0);
        send_request(OP_SEARCH, 0, 0, 5, 0, 0);
        write_register(CFG_EXP_LIMIT, 8191);
        send_request(OP_SEARCH, 0, 0, 6, 0, 0);
    endtask

    // Small map: a wall with a gap, obstacles off the map, a blocked start,
    // a clamped goal, an enclosed goal, clearing and a grid resize.
    task automatic test_small_map_cases();
        int y;
        set_registers(8, 8, 0, 4096);
        for (y = 0; y < 7; y++) send_request(OP_SET, 3, y, 0, 0, 0);
        send_request(OP_SET, 10, 2, 0, 0, 0);
        send_request(OP_SET, 0, 0, 0, 0, 0);
        send_request(OP_SEARCH, 0, 0, 63, 63, 0);
        send_request(OP_READ, 0, 0, 0, 0, 5);
        send_request(OP_SET, 3, 7, 0, 0, 0);
        send_request(OP_SEARCH, 0, 0, 7, 7, 0);
        send_request(OP_READ, 0, 0, 0, 0, 0);
        send_request(OP_CLEAR, 0, 0, 0, 0, 0);
        send_request(OP_SEARCH, 0, 0, 7, 0, 0);
        write_register(CFG_ALLOW_DIAG, 1);
        send_request(OP_SET, 1, 1, 0, 0, 0);
        write_register(CFG_GRID_HEIGHT, 5);
        send_request(OP_SEARCH, 0, 0, 7, 4, 0);
        send_request(OP_READ, 0, 0, 0, 0, 2);
    endtask

    // Random phases: a fresh register setting, then mostly well-formed map
    // building, a search and reads along its path, with some noise mixed in.
    task automatic test_random_traffic();
        int w, h, lim, n, i, sx, sy, gx, gy;
        while (sent_count < 95) begin
            if ($urandom_range(0, 9) == 0) begin
                w = $urandom_range(64, 127);
                h = $urandom_range(64, 127);
                lim = $urandom_range(1, 150);
            end else begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 12);
                lim = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : 4096;
            end
            set_registers(w, h, $urandom_range(0, 1), lim);
            w = sat_size(w);
            h = sat_size(h);
            if ($urandom_range(0, 2) == 0) send_request(OP_CLEAR, 0, 0, 0, 0, 0);
            n = $urandom_range(0, (w * h / 3 > 8) ? 8 : w * h / 3);
            for (i = 0; i < n; i++)
                send_request(OP_SET, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                             $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 4095));
            if ($urandom_range(0, 3) == 0)
                send_request(OP_SET, $urandom_range(0, 63), $urandom_range(0, 63),
                             0, 0, 0);
            if ($urandom_range(0, 4) == 0) begin
                sx = $urandom_range(0, 63); sy = $urandom_range(0, 63);
                gx = $urandom_range(0, 63); gy = $urandom_range(0, 63);
            end else begin
                sx = $urandom_range(0, w - 1); sy = $urandom_range(0, h - 1);
                gx = $urandom_range(0, w - 1); gy = $urandom_range(0, h - 1);
            end
            send_request(OP_SEARCH, sx, sy, gx, gy, $urandom_range(0, 4095));
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
                send_request(OP_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, route_len));
            if ($urandom_range(0, 3) == 0)
                send_request(OP_READ, 0, 0, 0, 0, $urandom_range(0, 4095));
            if ($urandom_range(0, 4) == 0)
                send_request(t_op'($urandom_range(0, 3)), $urandom_range(0, 63),
                             $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 63), $urandom_range(0, 4095));
        end
    endtask

    // Run-away guard, far beyond the slowest correct run.
    initial begin
        #400000000;
        $display("grid_astar_path_search_unit_tb: done, errors");
        $finish;
    end

    initial begin
        int i;
        // Every input is known from time zero, while reset is held low.
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req_type = OP_SET;
        i_cell_x = '0; i_cell_y = '0; i_goal_x = '0; i_goal_y = '0;
        i_path_index = '0;
        i_cfg_we = 1'b0; i_cfg_index = CFG_GRID_WIDTH; i_cfg_wdata = '0;
        for (i = 0; i < CELLS; i++) begin
            obst_map[i] = 1'b0;
            node_state[i] = NS_FREE;
        end
        open_n = 0; next_seq = 0; route_len = 0;
        reg_w = 64; reg_h = 64; reg_diag = 1; reg_limit = 4096;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_register_extremes();
        test_small_map_cases();
        test_random_traffic();

        // Let the last results drain, then allow a short quiet period so that
        // any stray strobe would still be caught.
        drain_requests();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && answers_due.size() == 0)
            $display("grid_astar_path_search_unit_tb: done, clean");
        else
            $display("grid_astar_path_search_unit_tb: done, errors");
        $finish;
    end

endmodule

// File: files.f
src/gas_pkg.sv
src/gas_front.sv
src/gas_engine.sv
src/grid_astar_path_search_unit.sv
dv/grid_astar_path_search_unit_tb.sv
